// ===== hw/rtl/ngga_pkg.sv =====
// Shared types, character codes and constants for the GGA position parser.
`timescale 1ns / 1ps

package ngga_pkg;

    // Payload widths
    localparam int BYTE_W = 8;
    localparam int ACC_W  = 31;
    localparam int DEG_W  = 22;
    localparam int MIN_W  = 27;
    localparam int FRAC_W = 20;
    localparam int DEGP_W = 46;
    localparam int Q_W    = 24;
    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int HDR_LEN = 5;

    // Characters of the sentence grammar
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_POINT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SOUTH   = 8'h53;
    localparam logic [BYTE_W-1:0] CH_WEST    = 8'h57;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    // Sentence header "GNGGA"
    localparam logic [BYTE_W-1:0] HDR_TEXT [HDR_LEN] = '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41};

    // Scaled-value limits and converted-value saturation
    localparam logic [ACC_W-1:0]  LAT_CAP = 31'd1073741823;
    localparam logic [ACC_W-1:0]  LON_CAP = 31'd2147483647;
    localparam logic [DEGP_W-1:0] LAT_SAT = 46'd900000000;
    localparam logic [DEGP_W-1:0] LON_SAT = 46'd1800000000;

    // Conversion constants: 1e7 per degree, reciprocal of six with a 30-bit shift
    localparam logic [23:0] DEG_MUL = 24'd10000000;
    localparam logic [27:0] RECIP6  = 28'd178956971;

    // Comma field being parsed
    typedef enum logic [2:0] {
        FLD_HDR_SEP,
        FLD_TIME,
        FLD_LAT,
        FLD_LAT_DIR,
        FLD_LON,
        FLD_LON_DIR,
        FLD_DONE
    } field_t;

    // Parsed fix handed from the parser to the conversion pipeline
    typedef struct packed {
        logic             ok;
        logic             south;
        logic             west;
        logic [DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0] lat_min;
        logic [DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0] lon_min;
    } fix_t;

    function automatic longint pow10(input int n);
        longint r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ngga_parser.sv =====
// Byte-wise GGA sentence parser: header match, field walk and running degree/minute split.
`timescale 1ns / 1ps

module ngga_parser import ngga_pkg::*; #(
    parameter int SENTENCE_LIMIT  = 128,
    parameter int MINUTE_DECIMALS = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              emit,
    output fix_t              fix
);

    localparam int POS_W = $clog2(SENTENCE_LIMIT + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(SENTENCE_LIMIT);
    localparam logic [POS_W-1:0] POS_HDR   = POS_W'(HDR_LEN);
    localparam logic [2:0]       MDEC      = 3'(MINUTE_DECIMALS);
    localparam logic [MIN_W-1:0] SCALE     = MIN_W'(pow10(MINUTE_DECIMALS));

    // Largest value that still survives k more decimal shifts
    localparam logic [ACC_W-1:0] LAT_LIM [8] = '{
        LAT_CAP / 1, LAT_CAP / 10, LAT_CAP / 100, LAT_CAP / 1000,
        LAT_CAP / 10000, LAT_CAP / 100000, LAT_CAP / 1000000, LAT_CAP / 10000000
    };
    localparam logic [ACC_W-1:0] LON_LIM [8] = '{
        LON_CAP / 1, LON_CAP / 10, LON_CAP / 100, LON_CAP / 1000,
        LON_CAP / 10000, LON_CAP / 100000, LON_CAP / 1000000, LON_CAP / 10000000
    };
    // Weight of a minute decimal, by decimals still to come
    localparam logic [FRAC_W-1:0] FRAC_WT [8] = '{
        20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000, 20'd100000, 20'd1000000, 20'd0
    };

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              hdr_reg, hdr_next;
    field_t            field_reg, field_next;
    logic [ACC_W-1:0]  accum_reg, accum_next;
    logic [2:0]        fdc_reg, fdc_next;
    logic              point_reg, point_next;
    logic              seen_reg, seen_next;
    logic [DEG_W-1:0]  deg_reg, deg_next;
    logic [6:0]        rem_reg, rem_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [DEG_W-1:0]  lat_deg_reg, lat_deg_next, lon_deg_reg, lon_deg_next;
    logic [MIN_W-1:0]  lat_min_reg, lat_min_next, lon_min_reg, lon_min_next;
    logic              south_reg, south_next, west_reg, west_next;
    logic              good_reg, good_next;

    logic              is_start, in_sentence, in_body;
    logic              is_comma, is_point, is_digit, is_nul;
    logic              keep, frac_full, acc_ovf, pad_ovf, fail, adv;
    logic [3:0]        digit, carry;
    logic [ACC_W-1:0]  cap, pad_lim;
    logic [ACC_W+3:0]  acc10;
    logic [2:0]        pad_k, wt_idx;
    logic [9:0]        rem10, rem_full;
    logic [15:0]       carry_prod;
    logic [FRAC_W-1:0] frac_wt;
    logic [MIN_W-1:0]  mins;
    logic [DEG_W-1:0]  deg_step;

    // Classify the beat
    assign is_start    = take && (rx_byte == CH_DOLLAR || rx_byte == CH_NEWLINE);
    assign in_sentence = take && !is_start && (pos_reg < POS_LIMIT);
    assign in_body     = in_sentence && (pos_reg >= POS_HDR);
    assign is_comma    = rx_byte == CH_COMMA;
    assign is_point    = rx_byte == CH_POINT;
    assign is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_nul      = rx_byte == CH_NUL;
    assign digit       = rx_byte[3:0];
    assign keep        = field_reg != FLD_TIME;

    // Overflow checks on the scaled value
    assign cap     = (field_reg == FLD_LAT) ? LAT_CAP : LON_CAP;
    assign acc10   = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                   + {{ACC_W{1'b0}}, digit};
    assign acc_ovf = acc10 > {4'b0000, cap};
    assign pad_k   = MDEC - fdc_reg;
    assign pad_lim = (field_reg == FLD_LAT) ? LAT_LIM[pad_k] : LON_LIM[pad_k];
    assign pad_ovf = accum_reg > pad_lim;

    // Minute decimals and whole-part split into degrees and minutes
    assign frac_full  = point_reg && (fdc_reg >= MDEC);
    assign wt_idx     = MDEC - 3'd1 - fdc_reg;
    assign frac_wt    = FRAC_WT[wt_idx];
    assign rem10      = {rem_reg, 3'b000} + {2'b00, rem_reg, 1'b0} + {6'b000000, digit};
    assign carry_prod = {6'b000000, rem10} * 16'd41;
    assign carry      = carry_prod[15:12];
    assign rem_full   = rem10 - ({6'b000000, carry} * 10'd100);
    assign deg_step   = (deg_reg * DEG_W'(10)) + DEG_W'(carry);
    assign mins       = (MIN_W'(rem_reg) * SCALE) + MIN_W'(frac_reg);

    // Decide fail or advance for the current field
    always_comb begin
        fail = 1'b0;
        adv  = 1'b0;
        if (in_body) begin
            unique case (field_reg)
                FLD_HDR_SEP: begin
                    adv  = is_comma;
                    fail = !is_comma;
                end
                FLD_TIME, FLD_LAT, FLD_LON: begin
                    priority if (is_comma) begin
                        fail = !seen_reg || (keep && pad_ovf);
                        adv  = !fail;
                    end else if (is_point) begin
                        fail = point_reg;
                    end else if (is_digit) begin
                        fail = !frac_full && keep && acc_ovf;
                    end else begin
                        fail = 1'b1;
                    end
                end
                FLD_LAT_DIR: begin
                    if (is_comma) begin
                        fail = !seen_reg;
                        adv  = seen_reg;
                    end else begin
                        fail = seen_reg || is_nul;
                    end
                end
                FLD_LON_DIR: begin
                    fail = is_nul;
                    adv  = !is_nul;
                end
                default: begin
                end
            endcase
        end
    end

    // Field sequence
    always_comb begin
        field_next = field_reg;
        priority if (is_start) begin
            field_next = FLD_HDR_SEP;
        end else if (fail) begin
            field_next = FLD_DONE;
        end else if (adv) begin
            unique case (field_reg)
                FLD_HDR_SEP: field_next = FLD_TIME;
                FLD_TIME:    field_next = FLD_LAT;
                FLD_LAT:     field_next = FLD_LAT_DIR;
                FLD_LAT_DIR: field_next = FLD_LON;
                FLD_LON:     field_next = FLD_LON_DIR;
                default:     field_next = FLD_DONE;
            endcase
        end
    end

    // Running values of the sentence
    always_comb begin
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        accum_next   = accum_reg;
        fdc_next     = fdc_reg;
        point_next   = point_reg;
        seen_next    = seen_reg;
        deg_next     = deg_reg;
        rem_next     = rem_reg;
        frac_next    = frac_reg;
        lat_deg_next = lat_deg_reg;
        lat_min_next = lat_min_reg;
        lon_deg_next = lon_deg_reg;
        lon_min_next = lon_min_reg;
        south_next   = south_reg;
        west_next    = west_reg;
        good_next    = good_reg;
        if (is_start) begin
            pos_next     = '0;
            hdr_next     = 1'b0;
            accum_next   = '0;
            fdc_next     = '0;
            point_next   = 1'b0;
            seen_next    = 1'b0;
            deg_next     = '0;
            rem_next     = '0;
            frac_next    = '0;
            lat_deg_next = '0;
            lat_min_next = '0;
            lon_deg_next = '0;
            lon_min_next = '0;
            south_next   = 1'b0;
            west_next    = 1'b0;
            good_next    = 1'b0;
        end else if (in_sentence) begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < POS_HDR) begin
                if (pos_reg == '0) begin
                    good_next = 1'b1;
                end
                hdr_next = ((pos_reg == '0) || hdr_reg) && (rx_byte == HDR_TEXT[pos_reg[2:0]]);
            end else if (fail) begin
                good_next = 1'b0;
            end else if (adv) begin
                // Store the finished field, then clear for the next one
                if (field_reg == FLD_LAT) begin
                    lat_deg_next = deg_reg;
                    lat_min_next = mins;
                end
                if (field_reg == FLD_LON) begin
                    lon_deg_next = deg_reg;
                    lon_min_next = mins;
                end
                if (field_reg == FLD_LON_DIR) begin
                    west_next = rx_byte == CH_WEST;
                end
                accum_next = '0;
                fdc_next   = '0;
                point_next = 1'b0;
                seen_next  = 1'b0;
                deg_next   = '0;
                rem_next   = '0;
                frac_next  = '0;
            end else begin
                unique case (field_reg)
                    FLD_TIME, FLD_LAT, FLD_LON: begin
                        if (is_point) begin
                            point_next = 1'b1;
                        end
                        if (is_digit) begin
                            seen_next = 1'b1;
                            if (!frac_full) begin
                                if (keep) begin
                                    accum_next = acc10[ACC_W-1:0];
                                    if (point_reg) begin
                                        frac_next = frac_reg + (FRAC_W'(digit) * frac_wt);
                                    end else begin
                                        deg_next = deg_step;
                                        rem_next = rem_full[6:0];
                                    end
                                end
                                if (point_reg) begin
                                    fdc_next = fdc_reg + 3'd1;
                                end
                            end
                        end
                    end
                    FLD_LAT_DIR: begin
                        south_next = rx_byte == CH_SOUTH;
                        seen_next  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            hdr_reg     <= 1'b0;
            field_reg   <= FLD_HDR_SEP;
            accum_reg   <= '0;
            fdc_reg     <= '0;
            point_reg   <= 1'b0;
            seen_reg    <= 1'b0;
            deg_reg     <= '0;
            rem_reg     <= '0;
            frac_reg    <= '0;
            lat_deg_reg <= '0;
            lat_min_reg <= '0;
            lon_deg_reg <= '0;
            lon_min_reg <= '0;
            south_reg   <= 1'b0;
            west_reg    <= 1'b0;
            good_reg    <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            hdr_reg     <= hdr_next;
            field_reg   <= field_next;
            accum_reg   <= accum_next;
            fdc_reg     <= fdc_next;
            point_reg   <= point_next;
            seen_reg    <= seen_next;
            deg_reg     <= deg_next;
            rem_reg     <= rem_next;
            frac_reg    <= frac_next;
            lat_deg_reg <= lat_deg_next;
            lat_min_reg <= lat_min_next;
            lon_deg_reg <= lon_deg_next;
            lon_min_reg <= lon_min_next;
            south_reg   <= south_next;
            west_reg    <= west_next;
            good_reg    <= good_next;
        end
    end

    // Release a fix when a newline closes a GNGGA sentence of legal length
    assign emit = take && (rx_byte == CH_NEWLINE) && hdr_reg
               && (pos_reg >= POS_HDR) && (pos_reg < POS_LIMIT);

    always_comb begin
        fix.ok      = good_reg && (field_reg == FLD_DONE);
        fix.south   = south_reg;
        fix.west    = west_reg;
        fix.lat_deg = lat_deg_reg;
        fix.lat_min = lat_min_reg;
        fix.lon_deg = lon_deg_reg;
        fix.lon_min = lon_min_reg;
    end

endmodule

// ===== hw/rtl/ngga_convert.sv =====
// Four-stage pipeline turning degrees and scaled minutes into signed 1e-7 degree units.
`timescale 1ns / 1ps

module ngga_convert import ngga_pkg::*; #(
    parameter int MINUTE_DECIMALS = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  fix_t             in_fix,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [LAT_W-1:0] out_lat,
    output logic [LON_W-1:0] out_lon,
    output logic             out_ok
);

    // minutes * 10^(6-M) / 6 gives minutes / 60 in 1e-7 degree
    localparam logic [MIN_W-1:0] MIN_MUL = MIN_W'(pow10(6 - MINUTE_DECIMALS));

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              rdy2, rdy3, rdy4;
    fix_t              s1_fix_reg;
    logic [2:0]        s2_flags_reg, s3_flags_reg;
    logic [DEGP_W-1:0] s2_lat_degp_reg, s2_lon_degp_reg, s3_lat_degp_reg, s3_lon_degp_reg;
    logic [MIN_W-1:0]  s2_lat_y_reg, s2_lon_y_reg;
    logic [Q_W-1:0]    s3_lat_q_reg, s3_lon_q_reg;
    logic [LAT_W-1:0]  lat_reg, lat_next;
    logic [LON_W-1:0]  lon_reg, lon_next;
    logic              ok_reg;
    logic [DEGP_W-1:0] lat_degp, lon_degp, lat_mag, lon_mag;
    logic [MIN_W-1:0]  lat_y, lon_y;
    logic [54:0]       lat_prod, lon_prod;

    function automatic logic [DEGP_W-1:0] clamp_sum(input logic [DEGP_W-1:0] degp,
                                                    input logic [Q_W-1:0] q,
                                                    input logic [DEGP_W-1:0] sat);
        logic [DEGP_W-1:0] v;
        v = degp + DEGP_W'(q);
        return (v > sat) ? sat : v;
    endfunction

    // Advance a stage when the one after it is empty or moving
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = !v1_reg || rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage two: degrees to 1e-7 units, minutes to a common scale
    assign lat_degp = s1_fix_reg.lat_deg * DEG_MUL;
    assign lon_degp = s1_fix_reg.lon_deg * DEG_MUL;
    assign lat_y    = s1_fix_reg.lat_min * MIN_MUL;
    assign lon_y    = s1_fix_reg.lon_min * MIN_MUL;

    // Stage three: divide by six through the reciprocal
    assign lat_prod = s2_lat_y_reg * RECIP6;
    assign lon_prod = s2_lon_y_reg * RECIP6;

    // Stage four: sum, saturate and apply the hemisphere sign, or zero a failed fix
    assign lat_mag  = clamp_sum(s3_lat_degp_reg, s3_lat_q_reg, LAT_SAT);
    assign lon_mag  = clamp_sum(s3_lon_degp_reg, s3_lon_q_reg, LON_SAT);

    always_comb begin
        lat_next = '0;
        lon_next = '0;
        if (s3_flags_reg[2]) begin
            lat_next = s3_flags_reg[1] ? (LAT_W'(0) - lat_mag[LAT_W-1:0]) : lat_mag[LAT_W-1:0];
            lon_next = s3_flags_reg[0] ? (LON_W'(0) - lon_mag[LON_W-1:0]) : lon_mag[LON_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            s1_fix_reg <= in_fix;
        end
        if (rdy2) begin
            s2_flags_reg    <= {s1_fix_reg.ok, s1_fix_reg.south, s1_fix_reg.west};
            s2_lat_degp_reg <= lat_degp;
            s2_lon_degp_reg <= lon_degp;
            s2_lat_y_reg    <= lat_y;
            s2_lon_y_reg    <= lon_y;
        end
        if (rdy3) begin
            s3_flags_reg    <= s2_flags_reg;
            s3_lat_degp_reg <= s2_lat_degp_reg;
            s3_lon_degp_reg <= s2_lon_degp_reg;
            s3_lat_q_reg    <= lat_prod[53:30];
            s3_lon_q_reg    <= lon_prod[53:30];
        end
        if (rdy4) begin
            lat_reg <= lat_next;
            lon_reg <= lon_next;
            ok_reg  <= s3_flags_reg[2];
        end
    end

    assign out_valid = v4_reg;
    assign out_lat   = lat_reg;
    assign out_lon   = lon_reg;
    assign out_ok    = ok_reg;

endmodule

// ===== hw/rtl/nmea_gga_position_parser.sv =====
// Top level: NMEA byte stream in, GNGGA latitude/longitude fix out.
// Path: the fix taken at the edge that accepts the closing newline passes the capture,
// scale, reciprocal and output registers of the conversion pipeline before m_tvalid rises.
// Throughput: one byte per cycle; s_tready falls only while all four pipeline stages
// hold results that m_tready is not taking.
// Reset: synchronous aresetn clears the sentence state and every pipeline valid.
`timescale 1ns / 1ps

module nmea_gga_position_parser import ngga_pkg::*; #(
    parameter int SENTENCE_LIMIT  = 128,
    parameter int MINUTE_DECIMALS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [30:0] latitude, [62:31] longitude, [63] zero
    output logic        m_tuser    // [0] parsed_ok
);

    logic             take;
    logic             emit;
    fix_t             fix;
    logic             conv_ready;
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;

    // Accept a beat whenever the pipeline can take a possible fix
    assign s_tready = conv_ready;
    assign take     = s_tvalid && conv_ready;

    ngga_parser #(
        .SENTENCE_LIMIT  (SENTENCE_LIMIT),
        .MINUTE_DECIMALS (MINUTE_DECIMALS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .rx_byte (s_tdata),
        .emit    (emit),
        .fix     (fix)
    );

    ngga_convert #(
        .MINUTE_DECIMALS (MINUTE_DECIMALS)
    ) u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (emit),
        .in_ready  (conv_ready),
        .in_fix    (fix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_lat   (lat),
        .out_lon   (lon),
        .out_ok    (m_tuser)
    );

    // Pack the result beat
    assign m_tdata = {1'b0, lon, lat};

endmodule

// ===== hw/rtl/ngga_checker.sv =====
// Port-level checks for the GGA position parser, bound to the top level.
`timescale 1ns / 1ps

module ngga_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Drop all coordinates on a failed parse
    a_zero_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("failed parse carries non-zero coordinates");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Latitude stays within the saturation bound
    a_lat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[30:0]) <= 31'sd900000000)
                  && ($signed(m_tdata[30:0]) >= -31'sd900000000))
        else $error("latitude out of range");

    // Longitude stays within the saturation bound
    a_lon_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[62:31]) <= 32'sd1800000000)
                  && ($signed(m_tdata[62:31]) >= -32'sd1800000000))
        else $error("longitude out of range");

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (.*);

// ===== verif/gga_fix_checker.sv =====
// Checker for the GGA position parser: follows the byte stream, predicts each fix, compares.
`timescale 1ns / 1ps

module gga_fix_checker import ngga_pkg::*; #(
    parameter int SENTENCE_LIMIT  = 128,
    parameter int MINUTE_DECIMALS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [30:0] latitude, [62:31] longitude, [63] zero
    input  logic        m_tuser,   // [0] parsed_ok
    output int          fail_count,
    output int          fixes_pending
);

    localparam longint unsigned MIN_SCALE     = 64'd10 ** MINUTE_DECIMALS;
    localparam longint unsigned UNITS_PER_DEG = 64'd10000000;
    localparam int              MAX_REPORTS   = 10;

    typedef struct packed {
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic             ok;
    } gga_fix_t;

    gga_fix_t fix_q[$];
    int       mism_cnt = 0;
    int       pend_cnt = 0;

    // Running sentence state
    int unsigned      sent_len;
    bit               hdr_ok;
    field_t           fld;
    logic [ACC_W-1:0] accum;
    int unsigned      frac_cnt;
    bit               point_seen;
    bit               char_seen;
    logic [ACC_W-1:0] lat_scaled;
    logic [ACC_W-1:0] lon_scaled;
    bit               is_south;
    bit               is_west;
    bit               all_good;

    assign fail_count    = mism_cnt;
    assign fixes_pending = pend_cnt;

    function automatic void clear_sentence();
        sent_len   = 0;
        hdr_ok     = 1'b0;
        fld        = FLD_HDR_SEP;
        accum      = '0;
        frac_cnt   = 0;
        point_seen = 1'b0;
        char_seen  = 1'b0;
        lat_scaled = '0;
        lon_scaled = '0;
        is_south   = 1'b0;
        is_west    = 1'b0;
        all_good   = 1'b0;
    endfunction

    function automatic void abort_parse();
        all_good = 1'b0;
        fld      = FLD_DONE;
    endfunction

    function automatic void advance_field();
        fld        = field_t'(fld + 1);
        accum      = '0;
        frac_cnt   = 0;
        point_seen = 1'b0;
        char_seen  = 1'b0;
    endfunction

    // Degrees plus minutes/60 in 1e-7 degree, truncated and clamped
    function automatic longint unsigned to_deg_units(longint unsigned raw, longint unsigned sat);
        longint unsigned deg;
        longint unsigned mins;
        longint unsigned v;
        deg  = raw / (100 * MIN_SCALE);
        mins = raw % (100 * MIN_SCALE);
        v    = deg * UNITS_PER_DEG + (mins * UNITS_PER_DEG) / (60 * MIN_SCALE);
        return (v > sat) ? sat : v;
    endfunction

    // Time, latitude and longitude: digits with at most one point
    function automatic void take_number_char(logic [7:0] b);
        logic [ACC_W-1:0] cap;
        logic [ACC_W-1:0] d;
        bit               keep;
        cap  = (fld == FLD_LAT) ? LAT_CAP : LON_CAP;
        keep = (fld != FLD_TIME);
        if (b == CH_COMMA) begin
            if (!char_seen) begin
                abort_parse();
                return;
            end
            if (keep) begin
                // pad the value out to the full count of minute decimals
                while (frac_cnt < MINUTE_DECIMALS) begin
                    if (accum > cap / 10) begin
                        abort_parse();
                        return;
                    end
                    accum    = accum * 10;
                    frac_cnt = frac_cnt + 1;
                end
                if (fld == FLD_LAT) lat_scaled = accum;
                else lon_scaled = accum;
            end
            advance_field();
        end else if (b == CH_POINT) begin
            if (point_seen) abort_parse();
            else point_seen = 1'b1;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            d         = ACC_W'(b - CH_ZERO);
            char_seen = 1'b1;
            // surplus decimals are checked but dropped
            if (point_seen && frac_cnt >= MINUTE_DECIMALS) return;
            if (keep) begin
                if (accum > (cap - d) / 10) begin
                    abort_parse();
                    return;
                end
                accum = accum * 10 + d;
            end
            if (point_seen) frac_cnt = frac_cnt + 1;
        end else begin
            abort_parse();
        end
    endfunction

    function automatic void take_body_char(logic [7:0] b);
        if (sent_len == 0) all_good = 1'b1;
        if (sent_len < HDR_LEN) begin
            hdr_ok = (sent_len == 0 || hdr_ok) && b == HDR_TEXT[sent_len];
            return;
        end
        case (fld)
            FLD_HDR_SEP: begin
                if (b == CH_COMMA) advance_field();
                else abort_parse();
            end
            FLD_TIME, FLD_LAT, FLD_LON: begin
                take_number_char(b);
            end
            FLD_LAT_DIR: begin
                if (b == CH_COMMA) begin
                    if (char_seen) advance_field();
                    else abort_parse();
                end else if (char_seen || b == CH_NUL) begin
                    abort_parse();
                end else begin
                    is_south  = (b == CH_SOUTH);
                    char_seen = 1'b1;
                end
            end
            FLD_LON_DIR: begin
                if (b == CH_NUL) begin
                    abort_parse();
                end else begin
                    is_west = (b == CH_WEST);
                    fld     = FLD_DONE;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Advance the sentence by one received byte; a closing newline may yield a fix
    function automatic void take_rx_byte(logic [7:0] b);
        gga_fix_t        fix;
        longint unsigned la;
        longint unsigned lo;
        if (b == CH_DOLLAR) begin
            clear_sentence();
        end else if (b == CH_NEWLINE) begin
            if (hdr_ok && sent_len >= HDR_LEN && sent_len < SENTENCE_LIMIT) begin
                fix.ok = all_good && fld == FLD_DONE;
                la     = 0;
                lo     = 0;
                if (fix.ok) begin
                    la = to_deg_units(64'(lat_scaled), 64'(LAT_SAT));
                    lo = to_deg_units(64'(lon_scaled), 64'(LON_SAT));
                    if (is_south) la = -la;
                    if (is_west) lo = -lo;
                end
                fix.lat = la[LAT_W-1:0];
                fix.lon = lo[LON_W-1:0];
                fix_q.push_back(fix);
            end
            clear_sentence();
        end else if (sent_len < SENTENCE_LIMIT) begin
            take_body_char(b);
            sent_len = sent_len + 1;
        end
    endfunction

    function automatic void log_mismatch(string what, gga_fix_t want, gga_fix_t got);
        mism_cnt = mism_cnt + 1;
        if (mism_cnt <= MAX_REPORTS)
            $display("%0t: %s: expected lat %0d lon %0d ok %0b, got lat %0d lon %0d ok %0b",
                     $realtime, what, $signed(want.lat), $signed(want.lon), want.ok,
                     $signed(got.lat), $signed(got.lon), got.ok);
    endfunction

    // Compare each result beat with the oldest prediction, then take the input beat
    always @(posedge aclk) begin : watch_proc
        gga_fix_t got;
        gga_fix_t want;
        if (!aresetn) begin
            clear_sentence();
            fix_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.lat = m_tdata[LAT_W-1:0];
                got.lon = m_tdata[LAT_W+LON_W-1:LAT_W];
                got.ok  = m_tuser;
                if (fix_q.size() == 0) begin
                    log_mismatch("fix with none outstanding", '0, got);
                end else begin
                    want = fix_q.pop_front();
                    if (got.lat !== want.lat || got.lon !== want.lon || got.ok !== want.ok)
                        log_mismatch("fix mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) take_rx_byte(s_tdata);
        end
        pend_cnt = fix_q.size();
    end

endmodule

// ===== verif/nmea_gga_position_parser_tb.sv =====
// Testbench top for the GGA position parser: byte stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module nmea_gga_position_parser_tb;
    import ngga_pkg::*;

    localparam int SENTENCE_LIMIT  = 128;
    localparam int MINUTE_DECIMALS = 5;
    localparam int ITEM_TARGET     = 1200;
    localparam int FIX_TARGET      = 48;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 12;
    localparam int CYCLE_LIMIT     = 400000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [30:0] latitude, [62:31] longitude, [63] zero
    logic        m_tuser;         // [0] parsed_ok
    int          fail_count;
    int          fixes_pending;

    bit          src_idle   = 1'b1;
    bit          sink_idle  = 1'b1;
    bit          hold_req   = 1'b0;
    int          beats_sent = 0;
    int          fixes_sent = 0;
    bit [7:0]    line_q[$];

    string directed_lines[] = '{
        "$GNGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n",
        "$GNGGA,235959,8959.99999,S,17959.99999,W,1\n",
        "$GNGGA,0,10737.41823,N,21474.83647,E\n",
        "$GNGGA,0,10737.41824,N,0,E\n",
        "$GNGGA,0,0,N,21474.83648,W\n",
        "$GNGGA,1.5,0.0,S,0.,W\n",
        "$GNGGA,120000.123456789,4807.0380099999,N,01131.9999999,E\n",
        "$GNGGA,,4807,N,1131,E\n",
        "$GNGGA,1,48..07,N,1131,E\n",
        "$GNGGA,1,-4807,N,1131,E\n",
        "$GNGGA,1,4807,NS,1131,E\n",
        "$GNGGA,1,4807,,1131,E\n",
        "$GNGGA,1,4807,N,1131,X,junk\n",
        "$GNGGAX,1,4807,N,1131,E\n",
        "$GNGGA,1,4807,N,1131\n",
        "$GNG\n",
        "$GNGGA\n",
        "$GPGGA,1,4807,N,1131,E\n",
        "GNGGA,1,.,N,1131,E\n",
        "$GNGGA,1,4807,N,1131,E$GNGGA,2,1,S,1,W\n",
        "\n"
    };

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    nmea_gga_position_parser #(
        .SENTENCE_LIMIT  (SENTENCE_LIMIT),
        .MINUTE_DECIMALS (MINUTE_DECIMALS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gga_fix_checker #(
        .SENTENCE_LIMIT  (SENTENCE_LIMIT),
        .MINUTE_DECIMALS (MINUTE_DECIMALS)
    ) u_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .fixes_pending (fixes_pending)
    );

    // Guard against a hung run
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin : sink_proc
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    function automatic string rand_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    // Offer one beat, with an optional idle burst first; return at the accepting edge
    task automatic push_byte(bit [7:0] b);
        bit ready_seen;
        if (src_idle && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        forever begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
            if (ready_seen) break;
        end
        beats_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) push_byte(line_q[i]);
        line_q.delete();
    endtask

    // Valid fix that runs to exactly n characters after the dollar
    task automatic add_padded_fix(int n);
        add_text("$GNGGA,0,1,N,1,E");
        while (line_q.size() < n + 1) add_text("x");
        line_q.push_back(CH_NEWLINE);
    endtask

    // Well-formed GNGGA sentence with random content
    task automatic compose_fix();
        int    pick;
        int    lat_deg;
        int    lon_deg;
        string lat_txt;
        string lon_txt;
        string ns;
        string ew;
        pick    = $urandom_range(0, 19);
        lat_deg = (pick == 0) ? $urandom_range(90, 107) : $urandom_range(0, 89);
        lon_deg = (pick == 1) ? $urandom_range(180, 214) : $urandom_range(0, 179);
        lat_txt = $sformatf("%02d%02d", lat_deg, $urandom_range(0, 59));
        lon_txt = $sformatf("%03d%02d", lon_deg, $urandom_range(0, 59));
        if ($urandom_range(0, 7) != 0) lat_txt = {lat_txt, ".", rand_digits($urandom_range(0, 8))};
        if ($urandom_range(0, 7) != 0) lon_txt = {lon_txt, ".", rand_digits($urandom_range(0, 8))};
        if (pick == 2) begin
            lat_txt = "10737.41823";
            lon_txt = "21474.83647";
        end
        ns = ($urandom_range(0, 1) != 0) ? "S" : "N";
        ew = ($urandom_range(0, 1) != 0) ? "W" : "E";
        if ($urandom_range(0, 9) != 0) add_text("$");
        add_text({"GNGGA,", rand_digits($urandom_range(1, 6)), ".", rand_digits(2), ",",
                  lat_txt, ",", ns, ",", lon_txt, ",", ew});
        if ($urandom_range(0, 1) != 0) add_text(",1,08,0.9,545.4,M,46.9,M,,*47");
        if ($urandom_range(0, 1) != 0) add_text("\r");
        line_q.push_back(CH_NEWLINE);
    endtask

    initial begin : stimulus
        int kind;
        int cut;
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sentences: extremes, malformed fields, header and length cases
        foreach (directed_lines[i]) begin
            add_text(directed_lines[i]);
            send_line();
        end
        add_text("$GNGGA,1,4807,N,1131,");
        line_q.push_back(CH_NUL);
        line_q.push_back(CH_NEWLINE);
        send_line();
        add_padded_fix(SENTENCE_LIMIT - 1);
        send_line();
        add_padded_fix(SENTENCE_LIMIT);
        send_line();

        // Hold the result side off while short fixes keep arriving
        hold_req = 1'b1;
        repeat (30) begin
            add_text({"$GNGGA,1,", rand_digits(4), ",S,", rand_digits(5), ",W\n"});
            send_line();
        end

        // Random sentences, mostly well formed, the rest broken or noise
        while (beats_sent < ITEM_TARGET || fixes_sent < FIX_TARGET) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            kind      = $urandom_range(0, 99);
            if (kind < 60) begin
                compose_fix();
                fixes_sent++;
            end else if (kind < 68) begin
                compose_fix();
                line_q[$urandom_range(1, line_q.size() - 2)] = 8'($urandom_range(0, 255));
            end else if (kind < 74) begin
                compose_fix();
                cut = $urandom_range(1, line_q.size() - 1);
                while (line_q.size() > cut) void'(line_q.pop_back());
                line_q.push_back(CH_NEWLINE);
            end else if (kind < 78) begin
                compose_fix();
                line_q[2] = "P";
            end else if (kind < 84) begin
                add_padded_fix($urandom_range(SENTENCE_LIMIT - 6, SENTENCE_LIMIT + 12));
            end else if (kind < 92) begin
                n = $urandom_range(1, 20);
                repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                line_q.push_back(CH_DOLLAR);
                n = $urandom_range(0, HDR_LEN);
                for (int i = 0; i < n; i++) line_q.push_back(HDR_TEXT[i]);
                line_q.push_back(CH_NEWLINE);
            end
            send_line();
        end

        // Closing stretch at full rate on both sides
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (8) begin
            compose_fix();
            send_line();
        end
        s_tvalid <= 1'b0;

        // Drain outstanding fixes, then allow for any stray late beat
        @(posedge aclk);
        wait (fixes_pending == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
